>>> rtl/core/mcr_pkg.sv
package mcr_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;

    localparam int COORD_W  = 11;
    localparam int OFFSET_W = 10;
    localparam int RADIUS_W = 9;
    localparam int DEC_W    = 12;
    localparam int POS_W    = 12;
    localparam int PIX_X_W  = 8;
    localparam int PIX_Y_W  = 9;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } action_t;

    // one position of the circle, ready to be drawn as eight points
    typedef struct packed
    {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [OFFSET_W-1:0]       a;
        logic [OFFSET_W-1:0]       b;
        logic                      done;
    } job_t;

endpackage

>>> rtl/core/mcr_front.sv
module mcr_front
    import mcr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [RADIUS_W-1:0]       radius,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  action_t                   action,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    output logic                      push,
    output job_t                      push_job,
    input  logic                      queue_full
);

    logic signed [COORD_W-1:0]  centre_col_reg, centre_col_next;
    logic signed [COORD_W-1:0]  centre_row_reg, centre_row_next;
    logic [OFFSET_W-1:0]        offset_a_reg, offset_a_next;
    logic [OFFSET_W-1:0]        offset_b_reg, offset_b_next;
    logic signed [DEC_W-1:0]    decision_reg, decision_next;
    logic                       active_reg, active_next;

    logic                       accept;
    logic                       can_step;
    logic signed [DEC_W+1:0]    dec_ext;
    logic signed [DEC_W+1:0]    two_a;
    logic signed [DEC_W+1:0]    two_b;
    logic signed [DEC_W+1:0]    sum_neg;
    logic signed [DEC_W+1:0]    sum_pos;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign can_step = active_reg && (offset_a_reg < offset_b_reg);

    assign dec_ext = $signed({{2{decision_reg[DEC_W-1]}}, decision_reg});
    assign two_a   = $signed({3'b000, offset_a_reg, 1'b0});
    assign two_b   = $signed({3'b000, offset_b_reg, 1'b0});
    assign sum_neg = dec_ext + two_a + 14'sd3;
    assign sum_pos = dec_ext + two_a - two_b + 14'sd5;

    always_comb
    begin
        centre_col_next = centre_col_reg;
        centre_row_next = centre_row_reg;
        offset_a_next   = offset_a_reg;
        offset_b_next   = offset_b_reg;
        decision_next   = decision_reg;
        active_next     = active_reg;
        push            = 1'b0;
        if (accept)
        begin
            unique case (action)
                ACT_START:
                begin
                    centre_col_next = center_x;
                    centre_row_next = center_y;
                    offset_a_next   = '0;
                    offset_b_next   = {1'b0, radius};
                    decision_next   = $signed(12'd1 - {3'b000, radius});
                    push            = 1'b1;
                end
                ACT_ADVANCE:
                begin
                    if (can_step)
                    begin
                        // update works on the offsets before they move
                        if (decision_reg[DEC_W-1])
                        begin
                            decision_next = sum_neg[DEC_W-1:0];
                        end
                        else
                        begin
                            decision_next = sum_pos[DEC_W-1:0];
                            offset_b_next = offset_b_reg - 10'd1;
                        end
                        offset_a_next = offset_a_reg + 10'd1;
                        push          = 1'b1;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
            if (push)
            begin
                active_next = offset_a_next < offset_b_next;
            end
        end
    end

    assign push_job.cx   = centre_col_next;
    assign push_job.cy   = centre_row_next;
    assign push_job.a    = offset_a_next;
    assign push_job.b    = offset_b_next;
    assign push_job.done = !(offset_a_next < offset_b_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_col_reg <= '0;
            centre_row_reg <= '0;
            offset_a_reg   <= '0;
            offset_b_reg   <= '0;
            decision_reg   <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            centre_col_reg <= centre_col_next;
            centre_row_reg <= centre_row_next;
            offset_a_reg   <= offset_a_next;
            offset_b_reg   <= offset_b_next;
            decision_reg   <= decision_next;
            active_reg     <= active_next;
        end
    end

    // a circle in progress always has room for another iteration
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (offset_a_reg < offset_b_reg))
        else $error("circle active with x offset not below y offset");

endmodule

>>> rtl/core/mcr_queue.sv
module mcr_queue
    import mcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t pop_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job taken from an empty queue");

endmodule

>>> rtl/core/mcr_back.sv
module mcr_back
    import mcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  job_t               queue_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_X_W-1:0] pixel_x,
    output logic [PIX_Y_W-1:0] pixel_y,
    output logic               pixel_valid,
    output logic               last_of_step,
    output logic               circle_done
);

    job_t               job_reg;
    logic               busy_reg, busy_next;
    logic [2:0]         point_reg, point_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIX_X_W-1:0] pixel_x_reg;
    logic [PIX_Y_W-1:0] pixel_y_reg;
    logic               pixel_valid_reg;
    logic               last_reg;
    logic               done_reg;

    logic                    advance;
    logic [OFFSET_W-1:0]     off_x;
    logic [OFFSET_W-1:0]     off_y;
    logic signed [POS_W-1:0] cx_ext;
    logic signed [POS_W-1:0] cy_ext;
    logic signed [POS_W-1:0] ox_ext;
    logic signed [POS_W-1:0] oy_ext;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    on_screen;

    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign pop     = !queue_empty && (!busy_reg || (advance && point_reg == 3'd7));

    // point order: bit 2 swaps the offsets, bit 1 mirrors x, bit 0 mirrors y
    assign off_x  = point_reg[2] ? job_reg.b : job_reg.a;
    assign off_y  = point_reg[2] ? job_reg.a : job_reg.b;
    assign cx_ext = POS_W'(job_reg.cx);
    assign cy_ext = POS_W'(job_reg.cy);
    assign ox_ext = $signed({2'b00, off_x});
    assign oy_ext = $signed({2'b00, off_y});
    assign pos_x  = point_reg[1] ? cx_ext - ox_ext : cx_ext + ox_ext;
    assign pos_y  = point_reg[0] ? cy_ext - oy_ext : cy_ext + oy_ext;

    assign on_screen = !pos_x[POS_W-1] && (pos_x < POS_W'(SCREEN_WIDTH))
                    && !pos_y[POS_W-1] && (pos_y < POS_W'(SCREEN_HEIGHT));

    always_comb
    begin
        busy_next      = busy_reg;
        point_next     = point_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            point_next     = point_reg + 3'd1;
            if (point_reg == 3'd7)
            begin
                busy_next = !queue_empty;
            end
        end
        else if (!busy_reg && !queue_empty)
        begin
            busy_next  = 1'b1;
            point_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= queue_job;
        end
        if (advance)
        begin
            pixel_x_reg     <= on_screen ? pos_x[PIX_X_W-1:0] : '0;
            pixel_y_reg     <= on_screen ? pos_y[PIX_Y_W-1:0] : '0;
            pixel_valid_reg <= on_screen;
            last_reg        <= (point_reg == 3'd7);
            done_reg        <= job_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            point_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            point_reg     <= point_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_valid  = pixel_valid_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (point_reg == 3'd0))
        else $error("point counter moved with no job loaded");

endmodule

>>> rtl/core/midpoint_circle_rasterizer_core.sv
// Midpoint circle rasterizer for a 240x320 screen. Write the radius on cfg_wr_en/cfg_wr_data
// while idle, then send a start transaction (tuser 0) carrying the centre, followed by advance
// transactions (tuser 1). Every start and every advance that still has an iteration left gives
// eight pixel transactions in octant order, the eighth marked by tlast; off-screen points come
// out with pixel_valid low and zero coordinates, and circle_done flags the final position. An
// advance with no circle in progress is accepted and gives nothing. The output register sets the
// sustained rate, sending one pixel per cycle while m_tready is high; the front end updates the
// circle state as each input is accepted and can run up to two positions ahead through a
// two-entry job queue, so input and output stall independently.
module midpoint_circle_rasterizer_core
    import mcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [RADIUS_W-1:0] cfg_wr_data,   // radius
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,       // center_x, center_y, zero pad
    input  logic [0:0]          s_tuser,       // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,       // pixel_x, pixel_y, zero pad
    output logic [1:0]          m_tuser,       // pixel_valid, circle_done
    output logic                m_tlast        // last_of_step
);

    logic [RADIUS_W-1:0] radius_reg;
    logic                push;
    logic                pop;
    logic                queue_full;
    logic                queue_empty;
    job_t                push_job;
    job_t                pop_job;
    action_t             action;
    logic [PIX_X_W-1:0]  pixel_x;
    logic [PIX_Y_W-1:0]  pixel_y;
    logic                pixel_valid;
    logic                circle_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    assign action = action_t'(s_tuser[0]);

    mcr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .radius     (radius_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (action),
        .center_x   ($signed(s_tdata[10:0])),
        .center_y   ($signed(s_tdata[21:11])),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    mcr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .pop_job  (pop_job)
    );

    mcr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .queue_job    (pop_job),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_valid  (pixel_valid),
        .last_of_step (m_tlast),
        .circle_done  (circle_done)
    );

    assign m_tdata = {7'd0, pixel_y, pixel_x};
    assign m_tuser = {circle_done, pixel_valid};

endmodule
